### rtl/plwm_pkg.sv
`default_nettype none

package plwm_pkg;

  // Fixed field widths of the channels.
  localparam int OP_W  = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int LEN_W = 7;
  localparam int ST_W  = 2;

  // Request codes; codes above OP_MOVE behave as a report.
  typedef enum logic [OP_W-1:0] {
    OP_REPORT = 3'd0,
    OP_INSERT = 3'd1,
    OP_QUERY  = 3'd2,
    OP_REMOVE = 3'd3,
    OP_MOVE   = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Kind of shift the cell row performs.
  typedef enum logic [1:0] {
    SH_NONE   = 2'd0,
    SH_INSERT = 2'd1,
    SH_REMOVE = 2'd2,
    SH_MOVE   = 2'd3
  } shift_t;

  // Command broadcast to every cell.
  typedef struct packed {
    shift_t                   kind;
    logic signed [VAL_W-1:0]  new_value;
    logic signed [VAL_W-1:0]  moved;
  } cell_cmd_t;

  // One node of the maximum tree: running maximum over the valid leaves
  // below it, and the value of the selected leaf (zero if none below).
  typedef struct packed {
    logic                     valid;
    logic signed [VAL_W-1:0]  max_v;
    logic        [VAL_W-1:0]  sel_v;
  } node_t;

  // Merge two tree nodes.
  function automatic node_t node_merge(input node_t l, input node_t r);
    node_t m;
    m.valid = l.valid | r.valid;
    if (l.valid && r.valid) begin
      m.max_v = ($signed(l.max_v) > $signed(r.max_v)) ? l.max_v : r.max_v;
    end else if (l.valid) begin
      m.max_v = l.max_v;
    end else begin
      m.max_v = r.max_v;
    end
    m.sel_v = l.sel_v | r.sel_v;
    return m;
  endfunction

endpackage

`default_nettype wire

### rtl/plwm_in_if.sv
`default_nettype none

// Request channel.
interface plwm_in_if;
  logic                                valid;
  logic                                ready;
  logic        [plwm_pkg::OP_W-1:0]    op;
  logic        [plwm_pkg::POS_W-1:0]   position;
  logic signed [plwm_pkg::VAL_W-1:0]   new_value;

  modport source (output valid, output op, output position, output new_value,
                  input ready);
  modport sink (input valid, input op, input position, input new_value,
                output ready);
endinterface

`default_nettype wire

### rtl/plwm_out_if.sv
`default_nettype none

// Result channel.
interface plwm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [plwm_pkg::VAL_W-1:0]   read_value;
  logic        [plwm_pkg::LEN_W-1:0]   length;
  logic signed [plwm_pkg::VAL_W-1:0]   max_value;
  logic        [plwm_pkg::ST_W-1:0]    status;

  modport source (output valid, output read_value, output length,
                  output max_value, output status, input ready);
  modport sink (input valid, input read_value, input length,
                input max_value, input status, output ready);
endinterface

`default_nettype wire

### rtl/plwm_cell.sv
`default_nettype none

// One storage cell of the list. It decides from its own index, the
// request position and the current count whether it keeps its value,
// takes a neighbor's value, or loads a new one.
module plwm_cell #(
  parameter int IDX = 0,
  parameter int XW  = 7
) (
  input  wire logic                                clk,
  input  wire plwm_pkg::cell_cmd_t                 cmd,
  input  wire logic        [XW-1:0]                pos,
  input  wire logic        [XW-1:0]                cnt,
  input  wire logic signed [plwm_pkg::VAL_W-1:0]   left_val,
  input  wire logic signed [plwm_pkg::VAL_W-1:0]   right_val,
  output logic signed      [plwm_pkg::VAL_W-1:0]   value
);

  localparam logic [XW-1:0] MY_IDX  = XW'(IDX);
  localparam logic [XW-1:0] MY_NEXT = XW'(IDX + 1);

  logic signed [plwm_pkg::VAL_W-1:0] value_r;
  logic signed [plwm_pkg::VAL_W-1:0] value_nxt;

  // Next value of this cell.
  always_comb begin
    value_nxt = value_r;
    case (cmd.kind)
      plwm_pkg::SH_INSERT: begin
        if (MY_IDX == pos) begin
          value_nxt = cmd.new_value;
        end else if (MY_IDX > pos && MY_IDX <= cnt) begin
          value_nxt = left_val;
        end
      end
      plwm_pkg::SH_REMOVE: begin
        if (MY_IDX >= pos && MY_NEXT < cnt) begin
          value_nxt = right_val;
        end
      end
      plwm_pkg::SH_MOVE: begin
        if (MY_IDX >= pos && MY_NEXT < cnt) begin
          value_nxt = right_val;
        end else if (MY_NEXT == cnt) begin
          value_nxt = cmd.moved;
        end
      end
      default: begin
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

`default_nettype wire

### rtl/plwm_max_tree.sv
`default_nettype none

// Registered binary tree over the cell row. Each level is one register
// stage, so the root lags the cells by one register stage per level.
// Besides the maximum it carries the value of the cell at the position.
module plwm_max_tree #(
  parameter int N  = 64,
  parameter int XW = 7
) (
  input  wire logic                                clk,
  input  wire logic signed [plwm_pkg::VAL_W-1:0]   cell_val [N],
  input  wire logic        [XW-1:0]                cnt,
  input  wire logic        [XW-1:0]                pos,
  output plwm_pkg::node_t                          root
);

  localparam int LVL = $clog2(N);
  localparam int P   = 1 << LVL;

  plwm_pkg::node_t leaf   [P];
  plwm_pkg::node_t node_r [1:P-1];

  // Leaves: valid below the count, selected at the position.
  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < N) begin : g_used
      always_comb begin
        leaf[j].valid = (XW'(j) < cnt);
        leaf[j].max_v = leaf[j].valid ? cell_val[j] : '0;
        leaf[j].sel_v = (XW'(j) == pos) ? cell_val[j] : '0;
      end
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  // Internal nodes, one register stage per level.
  for (genvar i = 1; i < P; i++) begin : g_node
    if (2 * i >= P) begin : g_bottom
      always_ff @(posedge clk) begin
        node_r[i] <= plwm_pkg::node_merge(leaf[2*i-P], leaf[2*i+1-P]);
      end
    end else begin : g_upper
      always_ff @(posedge clk) begin
        node_r[i] <= plwm_pkg::node_merge(node_r[2*i], node_r[2*i+1]);
      end
    end
  end

  assign root = node_r[1];

endmodule

`default_nettype wire

### rtl/positional_list_with_max.sv
// Positional list with running maximum.
//
// A request item on in_ch carries an op code, a position and a value.
// The block reports, inserts at a position, reads at a position, removes
// at a position, or moves the entry at a position to the end. Each request
// item gives exactly one result item on out_ch with the read value, the
// new length, the largest held value and a status code.
// Items are taken one at a time: a request is not accepted before the
// result of the last one is registered. Each request passes through the
// registered maximum tree over the cell row, of depth log2(CAPACITY),
// before its result is valid. An insert or remove with status OK shifts
// the cell row before the tree fill; a move with status OK shifts it
// after the tree fill.
// Out-of-range positions, insert into a full list and access to an empty
// list are flagged in the status and change nothing.
// Reset empties the list; no clearing pass is needed. The result is held
// in an output register: while the receiver stalls, the result stays
// stable and the next request waits in the final state until it is taken.
`default_nettype none

module positional_list_with_max #(
  parameter int CAPACITY = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  plwm_in_if.sink     in_ch,
  plwm_out_if.source  out_ch
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW  = (CW > plwm_pkg::POS_W) ? CW : plwm_pkg::POS_W;
  localparam int LVL = $clog2(CAPACITY);
  localparam int TW  = $clog2(LVL + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_TREE  = 5'b00100,
    S_MOVE  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]                     count_r, count_nxt;
  logic [TW-1:0]                     tcnt_r, tcnt_nxt;
  plwm_pkg::op_t                     op_r;
  plwm_pkg::status_t                 st_r, st_nxt;
  logic [XW-1:0]                     pos_r;
  logic signed [plwm_pkg::VAL_W-1:0] val_r;

  logic                              out_valid_r;
  logic signed [plwm_pkg::VAL_W-1:0] out_read_r;
  logic [plwm_pkg::LEN_W-1:0]        out_len_r;
  logic signed [plwm_pkg::VAL_W-1:0] out_max_r;
  plwm_pkg::status_t                 out_st_r;

  logic                              accept;
  logic                              deliver;
  logic [XW-1:0]                     pos_x;
  logic [XW-1:0]                     cnt_x;
  plwm_pkg::cell_cmd_t               cmd;
  plwm_pkg::node_t                   root;
  logic signed [plwm_pkg::VAL_W-1:0] cell_val [CAPACITY];

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign deliver     = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign pos_x       = XW'(in_ch.position);
  assign cnt_x       = XW'(count_r);

  // Status of an incoming request against the current count.
  always_comb begin
    st_nxt = plwm_pkg::ST_OK;
    case (plwm_pkg::op_t'(in_ch.op))
      plwm_pkg::OP_INSERT: begin
        if (count_r == CW'(CAPACITY)) begin
          st_nxt = plwm_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          st_nxt = plwm_pkg::ST_RANGE;
        end
      end
      plwm_pkg::OP_QUERY, plwm_pkg::OP_REMOVE, plwm_pkg::OP_MOVE: begin
        if (count_r == '0) begin
          st_nxt = plwm_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          st_nxt = plwm_pkg::ST_RANGE;
        end
      end
      default: begin
        st_nxt = plwm_pkg::ST_OK;
      end
    endcase
  end

  // Sequencer: optional shift, tree fill, optional move shift, result.
  always_comb begin
    state_nxt = state_r;
    tcnt_nxt  = tcnt_r;
    count_nxt = count_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          tcnt_nxt = TW'(LVL - 1);
          if (st_nxt == plwm_pkg::ST_OK &&
              (plwm_pkg::op_t'(in_ch.op) == plwm_pkg::OP_INSERT ||
               plwm_pkg::op_t'(in_ch.op) == plwm_pkg::OP_REMOVE)) begin
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_TREE;
          end
        end
      end
      S_SHIFT: begin
        if (op_r == plwm_pkg::OP_INSERT) begin
          count_nxt = count_r + CW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
        end
        state_nxt = S_TREE;
      end
      S_TREE: begin
        if (tcnt_r == '0) begin
          if (op_r == plwm_pkg::OP_MOVE && st_r == plwm_pkg::ST_OK) begin
            state_nxt = S_MOVE;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          tcnt_nxt = tcnt_r - TW'(1);
        end
      end
      S_MOVE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (deliver) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      tcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      tcnt_r  <= tcnt_nxt;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= plwm_pkg::op_t'(in_ch.op);
      st_r  <= st_nxt;
      pos_r <= pos_x;
      val_r <= in_ch.new_value;
    end
  end

  // Command for the cell row.
  always_comb begin
    cmd.kind      = plwm_pkg::SH_NONE;
    cmd.new_value = val_r;
    cmd.moved     = root.sel_v;
    if (state_r == S_SHIFT) begin
      cmd.kind = (op_r == plwm_pkg::OP_INSERT) ? plwm_pkg::SH_INSERT
                                               : plwm_pkg::SH_REMOVE;
    end else if (state_r == S_MOVE) begin
      cmd.kind = plwm_pkg::SH_MOVE;
    end
  end

  // Row of cells, each linked to its two neighbors.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [plwm_pkg::VAL_W-1:0] lv;
    logic signed [plwm_pkg::VAL_W-1:0] rv;
    if (k == 0) begin : g_first
      assign lv = '0;
    end else begin : g_left
      assign lv = cell_val[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign rv = '0;
    end else begin : g_right
      assign rv = cell_val[k+1];
    end
    plwm_cell #(
      .IDX (k),
      .XW  (XW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .pos       (pos_r),
      .cnt       (cnt_x),
      .left_val  (lv),
      .right_val (rv),
      .value     (cell_val[k])
    );
  end

  plwm_max_tree #(
    .N  (CAPACITY),
    .XW (XW)
  ) u_tree (
    .clk      (clk),
    .cell_val (cell_val),
    .cnt      (cnt_x),
    .pos      (pos_r),
    .root     (root)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (deliver) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      out_read_r <= (op_r == plwm_pkg::OP_QUERY && st_r == plwm_pkg::ST_OK)
                    ? $signed(root.sel_v) : '0;
      out_len_r  <= plwm_pkg::LEN_W'(count_r);
      out_max_r  <= root.valid ? root.max_v : '0;
      out_st_r   <= st_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_read_r;
  assign out_ch.length     = out_len_r;
  assign out_ch.max_value  = out_max_r;
  assign out_ch.status     = out_st_r;

endmodule

`default_nettype wire

### rtl/positional_list_with_max_chk.sv
`default_nettype none

// Port-level checks for the positional list.
module positional_list_with_max_chk #(
  parameter int CAPACITY = 64
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [plwm_pkg::VAL_W-1:0]   out_read_value,
  input wire logic        [plwm_pkg::LEN_W-1:0]   out_length,
  input wire logic signed [plwm_pkg::VAL_W-1:0]   out_max_value,
  input wire logic        [plwm_pkg::ST_W-1:0]    out_status
);

  localparam logic [plwm_pkg::LEN_W-1:0] CAP_LEN = plwm_pkg::LEN_W'(CAPACITY);

  // A stalled item holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value) &&
      $stable(out_length) && $stable(out_max_value) && $stable(out_status))
    else $error("result item changed while stalled");

  // An empty list reports a zero maximum.
  a_empty_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length == '0 |-> out_max_value == '0)
    else $error("nonzero maximum with empty list");

  // Status empty only with no entries.
  a_empty_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == plwm_pkg::ST_EMPTY |-> out_length == '0)
    else $error("empty status with entries held");

  // Status full only at capacity.
  a_full_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == plwm_pkg::ST_FULL |-> out_length == CAP_LEN)
    else $error("full status below capacity");

  // A failed request returns a zero read value.
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != plwm_pkg::ST_OK |-> out_read_value == '0)
    else $error("read value on a failed request");

endmodule

bind positional_list_with_max positional_list_with_max_chk #(
  .CAPACITY (CAPACITY)
) u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_value (out_ch.read_value),
  .out_length     (out_ch.length),
  .out_max_value  (out_ch.max_value),
  .out_status     (out_ch.status)
);

`default_nettype wire

### tb/sv/tb_positional_list_with_max.sv
`timescale 1ns / 100ps

module tb_positional_list_with_max;

  localparam int CAP          = 64;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 20;

  localparam int OP_W  = plwm_pkg::OP_W;
  localparam int POS_W = plwm_pkg::POS_W;
  localparam int VAL_W = plwm_pkg::VAL_W;
  localparam int LEN_W = plwm_pkg::LEN_W;

  // Op codes outside the defined set; the block treats them as a report.
  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] new_value;
    bit                      hold;
  } request_t;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        length;
    logic signed [VAL_W-1:0] max_value;
    plwm_pkg::status_t       status;
  } list_result_t;

  typedef enum {PH_GROW, PH_SHRINK, PH_MIX} phase_t;
  typedef enum {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_HEAVY} rx_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  plwm_in_if  in_ch();
  plwm_out_if out_ch();

  positional_list_with_max #(.CAPACITY(CAP)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Driven copies of the channel inputs, known from time zero.
  logic                    drv_valid = 1'b0;
  logic [OP_W-1:0]         drv_op    = '0;
  logic [POS_W-1:0]        drv_pos   = '0;
  logic signed [VAL_W-1:0] drv_value = '0;
  logic                    rcv_ready = 1'b0;

  assign in_ch.valid     = drv_valid;
  assign in_ch.op        = drv_op;
  assign in_ch.position  = drv_pos;
  assign in_ch.new_value = drv_value;
  assign out_ch.ready    = rcv_ready;

  request_t     request_queue[$];
  list_result_t pending_results[$];
  int unsigned  n_issued   = 0;
  int unsigned  n_accepted = 0;
  int unsigned  n_errors   = 0;
  int unsigned  gen_len    = 0;

  // Predicted contents of the list.
  logic signed [VAL_W-1:0] list_cells [CAP];
  int unsigned             list_len = 0;

  // Applies one request to the predicted list and returns its result.
  function automatic list_result_t list_apply(request_t r);
    list_result_t            res;
    logic signed [VAL_W-1:0] moved;
    int unsigned             k;
    res.read_value = '0;
    res.status     = plwm_pkg::ST_OK;
    case (r.op)
      plwm_pkg::OP_INSERT: begin
        if (list_len >= CAP) begin
          res.status = plwm_pkg::ST_FULL;
        end else if (r.position > list_len) begin
          res.status = plwm_pkg::ST_RANGE;
        end else begin
          for (k = list_len; k > r.position; k--) list_cells[k] = list_cells[k-1];
          list_cells[r.position] = r.new_value;
          list_len++;
        end
      end
      plwm_pkg::OP_QUERY, plwm_pkg::OP_REMOVE, plwm_pkg::OP_MOVE: begin
        if (list_len == 0) begin
          res.status = plwm_pkg::ST_EMPTY;
        end else if (r.position >= list_len) begin
          res.status = plwm_pkg::ST_RANGE;
        end else if (r.op == plwm_pkg::OP_QUERY) begin
          res.read_value = list_cells[r.position];
        end else begin
          moved = list_cells[r.position];
          for (k = r.position; k + 1 < list_len; k++) list_cells[k] = list_cells[k+1];
          if (r.op == plwm_pkg::OP_REMOVE) list_len--;
          else list_cells[list_len-1] = moved;
        end
      end
      default: begin
      end
    endcase
    res.length    = LEN_W'(list_len);
    res.max_value = '0;
    if (list_len != 0) begin
      res.max_value = list_cells[0];
      for (k = 1; k < list_len; k++)
        if (list_cells[k] > res.max_value) res.max_value = list_cells[k];
    end
    return res;
  endfunction

  // Queues one request and tracks the length it will leave behind.
  function automatic void push_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                   input logic signed [VAL_W-1:0] val, input bit hold);
    request_t r;
    r.op        = op;
    r.position  = pos;
    r.new_value = val;
    r.hold      = hold;
    request_queue.push_back(r);
    if (op == plwm_pkg::OP_INSERT && gen_len < CAP && pos <= gen_len) gen_len++;
    else if (op == plwm_pkg::OP_REMOVE && gen_len != 0 && pos < gen_len) gen_len--;
  endfunction

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    n_errors++;
  endtask

  // Request sender: bursts of items separated by random gaps.
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;

  always @(negedge clk) begin
    request_t nxt;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (n_issued == n_accepted) begin
      // The previous item has been taken; present the next one or idle.
      if (gap_left > 0) begin
        drv_valid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (request_queue.size() == 0 ||
                   (request_queue[0].hold && pending_results.size() != 0)) begin
        drv_valid <= 1'b0;
      end else begin
        nxt       = request_queue.pop_front();
        drv_valid <= 1'b1;
        drv_op    <= nxt.op;
        drv_pos   <= nxt.position;
        drv_value <= nxt.new_value;
        n_issued  <= n_issued + 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Result receiver: the stall behavior switches among random modes.
  rx_mode_t    rx_mode   = RX_ALWAYS;
  int unsigned mode_left = 0;
  logic [15:0] stall_pat = '1;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(20, 120);
      stall_pat <= 16'($urandom);
    end else begin
      mode_left <= mode_left - 1;
      if (rx_mode == RX_PATTERN) stall_pat <= {stall_pat[0], stall_pat[15:1]};
    end
    case (rx_mode)
      RX_ALWAYS:  rcv_ready <= 1'b1;
      RX_COIN:    rcv_ready <= 1'($urandom_range(0, 1));
      RX_PATTERN: rcv_ready <= stall_pat[0];
      default:    rcv_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Checks each result against the oldest prediction, then predicts
  // the result of any request item taken in the same cycle.
  always @(posedge clk) begin
    list_result_t want;
    request_t     seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending (length)",
                          VAL_W'(out_ch.length), '0);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.read_value !== want.read_value)
            report_mismatch("read_value", out_ch.read_value, want.read_value);
          if (out_ch.length !== want.length)
            report_mismatch("length", VAL_W'(out_ch.length), VAL_W'(want.length));
          if (out_ch.max_value !== want.max_value)
            report_mismatch("max_value", out_ch.max_value, want.max_value);
          if (out_ch.status !== want.status)
            report_mismatch("status", VAL_W'(out_ch.status), VAL_W'(want.status));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.op        = in_ch.op;
        seen.position  = in_ch.position;
        seen.new_value = in_ch.new_value;
        seen.hold      = 1'b0;
        pending_results.push_back(list_apply(seen));
        n_accepted <= n_accepted + 1;
      end
    end
  end

  initial begin
    phase_t                  ph;
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    int unsigned             n_random;
    int unsigned             stage;
    int unsigned             phase_left;
    int unsigned             extra;
    int unsigned             roll;
    int unsigned             lim;
    bit                      hold_next;

    // Directed part: empty list, single entry, extremes and bad positions.
    push_req(plwm_pkg::OP_REPORT, 0, 0, 1'b1);
    push_req(plwm_pkg::OP_QUERY, 0, 0, 1'b0);
    push_req(plwm_pkg::OP_REMOVE, 0, 0, 1'b0);
    push_req(plwm_pkg::OP_MOVE, 0, 0, 1'b0);
    push_req(plwm_pkg::OP_INSERT, 1, 32'sh1234_5678, 1'b0);
    push_req(plwm_pkg::OP_INSERT, 0, 32'sh8000_0000, 1'b0);
    push_req(plwm_pkg::OP_MOVE, 0, 0, 1'b0);
    push_req(plwm_pkg::OP_INSERT, 1, 32'sh7fff_ffff, 1'b0);
    push_req(plwm_pkg::OP_INSERT, 1, 0, 1'b0);
    push_req(plwm_pkg::OP_INSERT, 0, -1, 1'b0);
    push_req(plwm_pkg::OP_QUERY, 3, 0, 1'b0);
    push_req(plwm_pkg::OP_QUERY, 4, 0, 1'b0);
    push_req(plwm_pkg::OP_QUERY, 64, 0, 1'b0);
    push_req(plwm_pkg::OP_MOVE, 3, 0, 1'b0);
    push_req(plwm_pkg::OP_MOVE, 0, 0, 1'b0);
    push_req(plwm_pkg::OP_REMOVE, 4, 0, 1'b0);
    push_req(plwm_pkg::OP_REMOVE, 2, 0, 1'b0);
    push_req(OP_RSVD5, 63, 32'shAAAA_AAAA, 1'b0);
    push_req(OP_RSVD6, 0, 32'sh5555_5555, 1'b0);
    push_req(OP_RSVD7, 42, -1, 1'b0);
    push_req(plwm_pkg::OP_INSERT, 64, 32'sh0000_0001, 1'b0);
    push_req(plwm_pkg::OP_INSERT, 2, 32'sh5555_5555, 1'b0);
    push_req(plwm_pkg::OP_INSERT, 0, 32'shAAAA_AAAA, 1'b0);
    push_req(plwm_pkg::OP_QUERY, 0, 0, 1'b0);

    // Random part: fill to capacity and past it, drain to empty and past
    // it, then phases of random kind and length.
    n_random = 0;
    for (stage = 0; n_random < RANDOM_ITEMS; stage++) begin
      if (stage == 0) ph = PH_GROW;
      else if (stage == 1) ph = PH_SHRINK;
      else ph = phase_t'($urandom_range(0, 2));
      phase_left = $urandom_range(30, 80);
      extra      = 0;
      hold_next  = (stage <= 2);
      while (n_random < RANDOM_ITEMS) begin
        if (stage < 2) begin
          if ((ph == PH_GROW && gen_len == CAP) || (ph == PH_SHRINK && gen_len == 0)) extra++;
          if (extra > 8) break;
        end else begin
          if (phase_left == 0) break;
          phase_left--;
        end
        roll = $urandom_range(0, 99);
        case (ph)
          PH_GROW:
            op = roll < 70 ? plwm_pkg::OP_INSERT : roll < 80 ? plwm_pkg::OP_QUERY :
                 roll < 88 ? plwm_pkg::OP_MOVE : roll < 95 ? plwm_pkg::OP_REMOVE :
                 plwm_pkg::OP_REPORT;
          PH_SHRINK:
            op = roll < 55 ? plwm_pkg::OP_REMOVE : roll < 70 ? plwm_pkg::OP_QUERY :
                 roll < 85 ? plwm_pkg::OP_MOVE : roll < 95 ? plwm_pkg::OP_INSERT :
                 plwm_pkg::OP_REPORT;
          default:
            op = roll < 30 ? plwm_pkg::OP_INSERT : roll < 55 ? plwm_pkg::OP_QUERY :
                 roll < 75 ? plwm_pkg::OP_REMOVE : roll < 95 ? plwm_pkg::OP_MOVE :
                 roll < 97 ? plwm_pkg::OP_REPORT :
                 OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
        endcase
        // Mostly valid positions; the rest lean past the end.
        lim = (op == plwm_pkg::OP_INSERT) ? gen_len : (gen_len == 0 ? 0 : gen_len - 1);
        if ($urandom_range(0, 9) != 0) pos = POS_W'($urandom_range(0, lim));
        else pos = POS_W'($urandom_range(lim, CAP));
        case ($urandom_range(0, 6))
          0:       val = $urandom_range(0, 16) - 8;
          1:       val = ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
          default: val = $urandom;
        endcase
        push_req(op, pos, val, hold_next);
        hold_next = 1'b0;
        n_random++;
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (request_queue.size() != 0 || n_issued != n_accepted || pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("positional_list_with_max verification clean");
    end else begin
      $display("positional_list_with_max verification failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("timeout: %0d results still pending", pending_results.size());
    $display("positional_list_with_max verification failed");
    $finish;
  end

endmodule

### sim.f
rtl/plwm_pkg.sv
rtl/plwm_in_if.sv
rtl/plwm_out_if.sv
rtl/plwm_cell.sv
rtl/plwm_max_tree.sv
rtl/positional_list_with_max.sv
rtl/positional_list_with_max_chk.sv
tb/sv/tb_positional_list_with_max.sv
